/* hw/rtl/adu_pkg.sv */
package adu_pkg;

  // fixed point formats
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COEF_W   = 24;
  localparam int unsigned POWER_W  = 25;
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned DEPTH    = 4096;
  localparam int unsigned ACC_W    = 72;
  localparam int unsigned PROD_W   = 66;
  localparam int unsigned OPND_W   = 33;
  localparam int unsigned DIVD_W   = 56;
  localparam int unsigned DIVR_W   = 30;
  localparam int unsigned REM_W    = 34;
  localparam int unsigned G2_W     = 39;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [POWER_W-1:0] ONE_Q24 = 25'h100_0000;

  // register reset values
  localparam logic [COEF_W-1:0] LR_RST  = 24'd16777;
  localparam logic [COEF_W-1:0] B1_RST  = 24'd15099494;
  localparam logic [COEF_W-1:0] B2_RST  = 24'd16760438;
  localparam logic [COEF_W-1:0] EPS_RST = 24'd1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARNING_RATE  = 2'd0,
    CFG_FIRST_DECAY    = 2'd1,
    CFG_SECOND_DECAY   = 2'd2,
    CFG_STABILITY_TERM = 2'd3
  } cfg_idx_t;

  // multiply-accumulate request
  typedef struct packed {
    logic                     issue;
    logic                     accumulate;
    logic                     shift32;
    logic signed [OPND_W-1:0] a;
    logic signed [OPND_W-1:0] b;
  } mac_req_t;

  // shift-subtract unit request
  typedef struct packed {
    logic              start;
    logic              sqrt_mode;
    logic [DIVD_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } iter_req_t;

  // moment store write
  typedef struct packed {
    logic                     en;
    logic [ADDR_W-1:0]        addr;
    logic signed [VALUE_W-1:0] m;
    logic [VALUE_W-1:0]       v;
  } store_wr_t;

  function automatic logic signed [VALUE_W-1:0] sat_s32(input logic signed [63:0] x);
    logic signed [VALUE_W-1:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[VALUE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] sat_u32(input logic [63:0] x);
    logic [VALUE_W-1:0] r;
    if (x[63:VALUE_W] != '0) begin
      r = '1;
    end else begin
      r = x[VALUE_W-1:0];
    end
    return r;
  endfunction

  // divide by 2^24, round half away from zero
  function automatic logic signed [63:0] round_q24(input logic signed [ACC_W-1:0] acc);
    logic              neg;
    logic [ACC_W-1:0]  mag;
    logic [ACC_W-1:0]  q;
    neg = acc[ACC_W-1];
    mag = neg ? ACC_W'(-acc) : ACC_W'(acc);
    q   = (mag + ACC_W'(64'h80_0000)) >> 24;
    return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

endpackage

/* hw/rtl/adu_if.sv */
interface adu_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  starts_step;
  logic [adu_pkg::ADDR_W-1:0]            element_index;
  logic signed [adu_pkg::VALUE_W-1:0]    param_value;
  logic signed [adu_pkg::VALUE_W-1:0]    grad_value;
  modport source (output valid, starts_step, element_index, param_value, grad_value,
                  input ready);
  modport sink   (input valid, starts_step, element_index, param_value, grad_value,
                  output ready);
endinterface

interface adu_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [adu_pkg::VALUE_W-1:0]    new_param_value;
  modport source (output valid, new_param_value, input ready);
  modport sink   (input valid, new_param_value, output ready);
endinterface

interface adu_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [adu_pkg::CFG_IDX_W-1:0]         reg_index;
  logic [adu_pkg::COEF_W-1:0]            wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

/* hw/rtl/adu_mac.sv */
module adu_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  adu_pkg::mac_req_t                  req,
  output logic                               busy,
  output logic signed [adu_pkg::ACC_W-1:0]   acc
);

  logic                                pend_r;
  logic                                accum_r;
  logic                                shift_r;
  logic signed [adu_pkg::PROD_W-1:0]   prod_r;
  logic signed [adu_pkg::ACC_W-1:0]    acc_r;
  logic signed [adu_pkg::ACC_W-1:0]    ext;
  logic signed [adu_pkg::ACC_W-1:0]    addend;

  // product stage pending flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= req.issue;
    end
  end

  // operand product, then accumulate
  always_comb begin
    ext    = adu_pkg::ACC_W'(prod_r);
    addend = shift_r ? (ext <<< 32) : ext;
  end

  always_ff @(posedge clk) begin
    if (req.issue) begin
      prod_r  <= req.a * req.b;
      accum_r <= req.accumulate;
      shift_r <= req.shift32;
    end
    if (pend_r) begin
      acc_r <= (accum_r ? acc_r : '0) + addend;
    end
  end

  assign busy = pend_r;
  assign acc  = acc_r;

endmodule

/* hw/rtl/adu_iter.sv */
module adu_iter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  adu_pkg::iter_req_t           req,
  output logic                         busy,
  output logic [adu_pkg::DIVD_W-1:0]   quot
);

  logic                          busy_r;
  logic [5:0]                    cnt_r;
  logic                          sqrt_r;
  logic [adu_pkg::DIVD_W-1:0]    x_r;
  logic [adu_pkg::DIVR_W-1:0]    den_r;
  logic [adu_pkg::REM_W-1:0]     rem_r;
  logic [adu_pkg::DIVD_W-1:0]    q_r;
  logic [adu_pkg::REM_W-1:0]     rem_sh;
  logic [adu_pkg::REM_W-1:0]     trial;
  logic                          ge;

  // one quotient or root bit per cycle
  always_comb begin
    if (sqrt_r) begin
      rem_sh = {rem_r[adu_pkg::REM_W-3:0], x_r[adu_pkg::DIVD_W-1 -: 2]};
      trial  = {q_r[adu_pkg::REM_W-3:0], 2'b01};
    end else begin
      rem_sh = {rem_r[adu_pkg::REM_W-2:0], x_r[adu_pkg::DIVD_W-1]};
      trial  = adu_pkg::REM_W'(den_r);
    end
    ge = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.sqrt_mode ? 6'd27 : 6'd55;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sqrt_r <= req.sqrt_mode;
      x_r    <= req.dividend;
      den_r  <= req.divisor;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      x_r   <= sqrt_r ? (x_r << 2) : (x_r << 1);
      rem_r <= ge ? (rem_sh - trial) : rem_sh;
      q_r   <= {q_r[adu_pkg::DIVD_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

/* hw/rtl/adu_moment_store.sv */
module adu_moment_store (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [adu_pkg::ADDR_W-1:0]         rd_addr,
  input  adu_pkg::store_wr_t                 wr,
  output logic signed [adu_pkg::VALUE_W-1:0] rd_m,
  output logic [adu_pkg::VALUE_W-1:0]        rd_v,
  output logic                               ready
);

  logic signed [adu_pkg::VALUE_W-1:0] mem_m [adu_pkg::DEPTH];
  logic [adu_pkg::VALUE_W-1:0]        mem_v [adu_pkg::DEPTH];
  logic [adu_pkg::ADDR_W:0]           clr_cnt_r;
  logic                               clearing;
  logic                               we;
  logic [adu_pkg::ADDR_W-1:0]         waddr;
  logic signed [adu_pkg::VALUE_W-1:0] wm;
  logic [adu_pkg::VALUE_W-1:0]        wv;

  // clearing sweep after reset
  assign clearing = !clr_cnt_r[adu_pkg::ADDR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // write port shared by sweep and updates
  always_comb begin
    we    = clearing | wr.en;
    waddr = clearing ? clr_cnt_r[adu_pkg::ADDR_W-1:0] : wr.addr;
    wm    = clearing ? '0 : wr.m;
    wv    = clearing ? '0 : wr.v;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_m[waddr] <= wm;
      mem_v[waddr] <= wv;
    end
    rd_m <= mem_m[rd_addr];
    rd_v <= mem_v[rd_addr];
  end

  assign ready = !clearing;

endmodule

/* hw/rtl/adam_optimizer_update_unit.sv */
// adam update unit: one parameter element per input item
// in_ch carries starts_step, element_index, param_value and grad_value; out_ch
// returns new_param_value, one result item per input item; cfg_ch writes the
// learning rate, both decays and the stability term (always ready, write only
// while the unit is idle)
// an item runs three 56-step divisions and a 28-step root on the shared
// shift-subtract unit, after an update of the decay powers when starts_step
// is set; the multiplies all share a single registered multiply-accumulate
// unit
// one item is worked on at a time: in_ch.ready is high only in the idle state,
// so the next item is not taken before the last one is through
// after reset the moment store is swept to zero, one entry per cycle, over
// all 4096 entries; in_ch.ready stays low during the sweep, cfg writes are
// taken; powers of both decays return to 1.0 and registers to defaults
// the result sits in an output register: the next item is taken while it
// waits, but a finished item is held back until out_ch has drained
module adam_optimizer_update_unit (
  input  logic     clk,
  input  logic     rst_n,
  adu_in_if.sink   in_ch,
  adu_out_if.source out_ch,
  adu_cfg_if.sink  cfg_ch
);

  typedef enum logic [16:0] {
    ST_IDLE = 17'h00001,
    ST_RD   = 17'h00002,
    ST_PW1  = 17'h00004,
    ST_PW2  = 17'h00008,
    ST_PW3  = 17'h00010,
    ST_M1   = 17'h00020,
    ST_M2   = 17'h00040,
    ST_M3   = 17'h00080,
    ST_G1   = 17'h00100,
    ST_V1   = 17'h00200,
    ST_V2   = 17'h00400,
    ST_V3   = 17'h00800,
    ST_DM   = 17'h01000,
    ST_DV   = 17'h02000,
    ST_SQ   = 17'h04000,
    ST_L1   = 17'h08000,
    ST_DL   = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  logic [adu_pkg::COEF_W-1:0]          lr_r, b1_r, b2_r, eps_r;
  logic [adu_pkg::POWER_W-1:0]         p1_r, p2_r;
  logic                                starts_r;
  logic [adu_pkg::ADDR_W-1:0]          addr_r;
  logic signed [adu_pkg::VALUE_W-1:0]  param_r, grad_r, m_r, mhat_r;
  logic [adu_pkg::VALUE_W-1:0]         v_r;
  logic [adu_pkg::G2_W-1:0]            g2_r;
  logic [adu_pkg::DIVR_W-1:0]          d_r;
  logic                                step_neg_r;
  logic signed [adu_pkg::VALUE_W-1:0]  out_r;
  logic                                out_valid_r;

  adu_pkg::mac_req_t                   mac_req;
  adu_pkg::iter_req_t                  iter_req;
  adu_pkg::store_wr_t                  st_wr;
  logic                                mac_busy, iter_busy, store_rdy;
  logic signed [adu_pkg::ACC_W-1:0]    acc;
  logic [adu_pkg::DIVD_W-1:0]          quot;
  logic signed [adu_pkg::VALUE_W-1:0]  rd_m;
  logic [adu_pkg::VALUE_W-1:0]         rd_v;

  logic                                in_acc;
  logic                                go;
  logic [adu_pkg::POWER_W-1:0]         c1, c2, omb1, omb2;
  logic [adu_pkg::VALUE_W-1:0]         mmag, gmag, vhat, v_calc;
  logic signed [adu_pkg::VALUE_W-1:0]  m_calc;
  logic [adu_pkg::ACC_W-1:0]           acc_mag;
  logic [adu_pkg::ACC_W-1:0]           v_round;
  logic [adu_pkg::DIVR_W-1:0]          d_calc;
  logic signed [63:0]                  q_signed;
  logic signed [63:0]                  diff;

  adu_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .busy  (mac_busy),
    .acc   (acc)
  );

  adu_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (iter_req),
    .busy  (iter_busy),
    .quot  (quot)
  );

  adu_moment_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (addr_r),
    .wr      (st_wr),
    .rd_m    (rd_m),
    .rd_v    (rd_v),
    .ready   (store_rdy)
  );

  // handshakes
  assign in_ch.ready         = (state_r == ST_IDLE) && store_rdy;
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.new_param_value = out_r;

  // derived operands
  always_comb begin
    omb1    = adu_pkg::ONE_Q24 - adu_pkg::POWER_W'(b1_r);
    omb2    = adu_pkg::ONE_Q24 - adu_pkg::POWER_W'(b2_r);
    c1      = adu_pkg::ONE_Q24 - p1_r;
    c2      = adu_pkg::ONE_Q24 - p2_r;
    if (c1 == '0) c1 = adu_pkg::POWER_W'(1);
    if (c2 == '0) c2 = adu_pkg::POWER_W'(1);
    mmag    = m_r[31] ? adu_pkg::VALUE_W'(-m_r) : adu_pkg::VALUE_W'(m_r);
    gmag    = grad_r[31] ? adu_pkg::VALUE_W'(-grad_r) : adu_pkg::VALUE_W'(grad_r);
    m_calc  = adu_pkg::sat_s32(adu_pkg::round_q24(acc));
    v_round = (adu_pkg::ACC_W'(acc) + adu_pkg::ACC_W'(64'h80_0000)) >> 24;
    v_calc  = adu_pkg::sat_u32(v_round[63:0]);
    vhat    = adu_pkg::sat_u32(64'(quot));
    d_calc  = adu_pkg::DIVR_W'(quot[27:0]) + adu_pkg::DIVR_W'(eps_r);
    if (d_calc == '0) d_calc = adu_pkg::DIVR_W'(1);
    acc_mag = acc[adu_pkg::ACC_W-1] ? adu_pkg::ACC_W'(-acc) : adu_pkg::ACC_W'(acc);
    q_signed = step_neg_r ? -$signed(64'(quot)) : $signed(64'(quot));
    diff    = 64'(param_r) - q_signed;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    go        = 1'b0;
    mac_req   = '0;
    iter_req  = '0;
    st_wr     = '0;
    st_wr.addr = addr_r;
    st_wr.m    = m_r;
    st_wr.v    = v_calc;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = starts_r ? ST_PW1 : ST_M1;
      end
      ST_PW1: begin
        mac_req.issue = 1'b1;
        mac_req.a     = $signed({8'b0, p1_r});
        mac_req.b     = $signed({9'b0, b1_r});
        state_nxt     = ST_PW2;
      end
      ST_PW2: begin
        if (!mac_busy) begin
          go            = 1'b1;
          mac_req.issue = 1'b1;
          mac_req.a     = $signed({8'b0, p2_r});
          mac_req.b     = $signed({9'b0, b2_r});
          state_nxt     = ST_PW3;
        end
      end
      ST_PW3: begin
        if (!mac_busy) begin
          go        = 1'b1;
          state_nxt = ST_M1;
        end
      end
      ST_M1: begin
        mac_req.issue = 1'b1;
        mac_req.a     = $signed({9'b0, b1_r});
        mac_req.b     = $signed({rd_m[31], rd_m});
        state_nxt     = ST_M2;
      end
      ST_M2: begin
        mac_req.issue      = 1'b1;
        mac_req.accumulate = 1'b1;
        mac_req.a          = $signed({8'b0, omb1});
        mac_req.b          = $signed({grad_r[31], grad_r});
        state_nxt          = ST_M3;
      end
      ST_M3: begin
        if (!mac_busy) begin
          go            = 1'b1;
          mac_req.issue = 1'b1;
          mac_req.a     = $signed({1'b0, gmag});
          mac_req.b     = $signed({1'b0, gmag});
          state_nxt     = ST_G1;
        end
      end
      ST_G1: begin
        if (!mac_busy) begin
          go            = 1'b1;
          mac_req.issue = 1'b1;
          mac_req.a     = $signed({9'b0, b2_r});
          mac_req.b     = $signed({1'b0, rd_v});
          state_nxt     = ST_V1;
        end
      end
      ST_V1: begin
        mac_req.issue      = 1'b1;
        mac_req.accumulate = 1'b1;
        mac_req.a          = $signed({8'b0, omb2});
        mac_req.b          = $signed({1'b0, g2_r[31:0]});
        state_nxt          = ST_V2;
      end
      ST_V2: begin
        mac_req.issue      = 1'b1;
        mac_req.accumulate = 1'b1;
        mac_req.shift32    = 1'b1;
        mac_req.a          = $signed({8'b0, omb2});
        mac_req.b          = $signed({26'b0, g2_r[38:32]});
        state_nxt          = ST_V3;
      end
      ST_V3: begin
        if (!mac_busy) begin
          go                = 1'b1;
          st_wr.en          = 1'b1;
          iter_req.start    = 1'b1;
          iter_req.dividend = {mmag, 24'b0} + adu_pkg::DIVD_W'(c1 >> 1);
          iter_req.divisor  = adu_pkg::DIVR_W'(c1);
          state_nxt         = ST_DM;
        end
      end
      ST_DM: begin
        if (!iter_busy) begin
          go                = 1'b1;
          iter_req.start    = 1'b1;
          iter_req.dividend = {v_r, 24'b0} + adu_pkg::DIVD_W'(c2 >> 1);
          iter_req.divisor  = adu_pkg::DIVR_W'(c2);
          state_nxt         = ST_DV;
        end
      end
      ST_DV: begin
        if (!iter_busy) begin
          iter_req.start     = 1'b1;
          iter_req.sqrt_mode = 1'b1;
          iter_req.dividend  = {vhat, 24'b0};
          state_nxt          = ST_SQ;
        end
      end
      ST_SQ: begin
        if (!iter_busy) begin
          go            = 1'b1;
          mac_req.issue = 1'b1;
          mac_req.a     = $signed({9'b0, lr_r});
          mac_req.b     = $signed({mhat_r[31], mhat_r});
          state_nxt     = ST_L1;
        end
      end
      ST_L1: begin
        if (!mac_busy) begin
          go                = 1'b1;
          iter_req.start    = 1'b1;
          iter_req.dividend = acc_mag[adu_pkg::DIVD_W-1:0] + adu_pkg::DIVD_W'(d_r >> 1);
          iter_req.divisor  = d_r;
          state_nxt         = ST_DL;
        end
      end
      ST_DL: begin
        if (!iter_busy && !out_valid_r) begin
          go        = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      p1_r        <= adu_pkg::ONE_Q24;
      p2_r        <= adu_pkg::ONE_Q24;
      lr_r        <= adu_pkg::LR_RST;
      b1_r        <= adu_pkg::B1_RST;
      b2_r        <= adu_pkg::B2_RST;
      eps_r       <= adu_pkg::EPS_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DL && go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_PW2 && go) p1_r <= acc[48:24];
      if (state_r == ST_PW3 && go) p2_r <= acc[48:24];
      if (cfg_ch.valid) begin
        unique case (adu_pkg::cfg_idx_t'(cfg_ch.reg_index))
          adu_pkg::CFG_LEARNING_RATE:  lr_r  <= cfg_ch.wr_data;
          adu_pkg::CFG_FIRST_DECAY:    b1_r  <= cfg_ch.wr_data;
          adu_pkg::CFG_SECOND_DECAY:   b2_r  <= cfg_ch.wr_data;
          adu_pkg::CFG_STABILITY_TERM: eps_r <= cfg_ch.wr_data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      starts_r <= in_ch.starts_step;
      addr_r   <= in_ch.element_index;
      param_r  <= in_ch.param_value;
      grad_r   <= in_ch.grad_value;
    end
    if (state_r == ST_M3 && go) m_r <= m_calc;
    if (state_r == ST_G1 && go) begin
      g2_r <= adu_pkg::G2_W'((acc[63:0] + 64'h80_0000) >> 24);
    end
    if (state_r == ST_V3 && go) v_r <= v_calc;
    if (state_r == ST_DM && go) begin
      mhat_r <= adu_pkg::sat_s32(m_r[31] ? -$signed(64'(quot)) : $signed(64'(quot)));
    end
    if (state_r == ST_SQ && go) d_r <= d_calc;
    if (state_r == ST_L1 && go) step_neg_r <= acc[adu_pkg::ACC_W-1];
    if (state_r == ST_DL && go) out_r <= adu_pkg::sat_s32(diff);
  end

  // no item taken during the clearing sweep
  assert property (@(posedge clk) disable iff (!rst_n) !store_rdy |-> !in_ch.ready)
    else $error("item accepted during moment store clear");

  // an accepted item always goes to the store read next
  assert property (@(posedge clk) disable iff (!rst_n) in_acc |=> state_r == ST_RD)
    else $error("accepted item did not start the sequence");

  // the shift-subtract unit is never restarted while busy
  assert property (@(posedge clk) disable iff (!rst_n) iter_req.start |-> !iter_busy)
    else $error("iterative unit restarted while busy");

  // a pending result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_r))
    else $error("pending result lost");

endmodule

/* test/adu_tb_if.sv */
`timescale 1ns / 100ps

// the block's channel interfaces come with the rtl; this file only holds
// shared testbench types for the adam update checks
package adu_tb_pkg;
  import adu_pkg::*;

  // one input item
  typedef struct {
    bit                starts_step;
    bit [ADDR_W-1:0]   element_index;
    bit signed [31:0]  param_value;
    bit signed [31:0]  grad_value;
  } elem_item_t;
endpackage

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import adu_pkg::*;
  import adu_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  adu_in_if  in_ch();
  adu_out_if out_ch();
  adu_cfg_if cfg_ch();

  adam_optimizer_update_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  longint lr_q, b1_q, b2_q, eps_q;
  longint m_store [DEPTH];
  longint v_store [DEPTH];
  longint b1_pow, b2_pow;

  bit signed [31:0] param_queue [$];
  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  bit quiet_stretch = 0;

  function automatic longint clamp_s(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint clamp_u(longint x);
    if (x > 64'sd4294967295) return 64'sd4294967295;
    return x;
  endfunction

  // rounded division, halves away from zero
  function automatic longint rdiv(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint int_sqrt(longint x);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > x) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic void reset_model();
    foreach (m_store[i]) begin
      m_store[i] = 0;
      v_store[i] = 0;
    end
    b1_pow = 1 << 24;
    b2_pow = 1 << 24;
    lr_q = LR_RST;
    b1_q = B1_RST;
    b2_q = B2_RST;
    eps_q = EPS_RST;
  endfunction

  // adam update for one element, returns new parameter
  function automatic bit signed [31:0] adam_update(elem_item_t it);
    longint one, g, gm, g2, m, v, c1, c2, mh, vh, d, stp;
    int a;
    one = 64'sd1 <<< 24;
    a = it.element_index;
    g = it.grad_value;
    if (it.starts_step) begin
      b1_pow = (b1_pow * b1_q) >>> 24;
      b2_pow = (b2_pow * b2_q) >>> 24;
    end
    m = clamp_s(rdiv(b1_q * m_store[a] + (one - b1_q) * g, one));
    m_store[a] = m;
    gm = (g < 0) ? -g : g;
    g2 = (gm * gm + (one / 2)) >>> 24;
    v = clamp_u((b2_q * v_store[a] + (one - b2_q) * g2 + one / 2) >>> 24);
    v_store[a] = v;
    c1 = one - b1_pow;
    if (c1 == 0) c1 = 1;
    c2 = one - b2_pow;
    if (c2 == 0) c2 = 1;
    mh = clamp_s(rdiv(m * one, c1));
    vh = clamp_u((v * one + c2 / 2) / c2);
    d = int_sqrt(vh <<< 24) + eps_q;
    if (d == 0) d = 1;
    stp = rdiv(lr_q * mh, d);
    return 32'(clamp_s(longint'(it.param_value) - stp));
  endfunction

  function automatic bit take_gap();
    return !quiet_stretch && ($urandom_range(99) < 27);
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_seen++;
      if (param_queue.size() == 0) begin
        $display("%0t: unexpected item, got %0d", $realtime, out_ch.new_param_value);
        errors++;
      end else begin
        bit signed [31:0] want;
        want = param_queue.pop_front();
        if (want !== out_ch.new_param_value) begin
          $display("%0t: new_param_value expected %0d actual %0d",
                   $realtime, want, out_ch.new_param_value);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !take_gap();
    end
  end

  task automatic write_reg(cfg_idx_t idx, bit [23:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_LEARNING_RATE:  lr_q = val;
      CFG_FIRST_DECAY:    b1_q = val;
      CFG_SECOND_DECAY:   b2_q = val;
      CFG_STABILITY_TERM: eps_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (param_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // send one element, optionally checking a typed-in result
  task automatic send_elem(elem_item_t it, bit has_want, bit signed [31:0] want);
    bit signed [31:0] pred;
    @(negedge clk);
    while (take_gap()) @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.starts_step <= it.starts_step;
    in_ch.element_index <= it.element_index;
    in_ch.param_value <= it.param_value;
    in_ch.grad_value <= it.grad_value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = adam_update(it);
    if (has_want && pred !== want) begin
      $display("%0t: table row expected %0d actual prediction %0d", $realtime, want, pred);
      errors++;
    end
    param_queue.push_back(pred);
    n_sent++;
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  typedef struct {
    bit               s;
    bit [11:0]        a;
    bit signed [31:0] p;
    bit signed [31:0] g;
    bit               chk;
    bit signed [31:0] want;
  } row_t;

  // directed rows: zero gradients (checked) keep the parameter as is
  row_t rows [] = '{
    '{0, 12'd0,    32'sd0,          32'sd0,          1, 32'sd0},
    '{0, 12'd4095, 32'sh7FFFFFFF,   32'sd0,          1, 32'sh7FFFFFFF},
    '{0, 12'd1,    32'sh80000000,   32'sd0,          1, 32'sh80000000},
    '{0, 12'd2,    32'sd16777216,   32'sd16777216,   0, 0},
    '{1, 12'd2,    32'sd16777216,   32'sd16777216,   0, 0},
    '{1, 12'd3,    32'sh7FFFFFFF,   32'sh80000000,   0, 0},
    '{0, 12'd4,    32'sh80000000,   32'sh7FFFFFFF,   0, 0},
    '{1, 12'd4095, 32'sd0,          32'sh7FFFFFFF,   0, 0},
    '{0, 12'd4095, 32'sd0,          32'sh80000000,   0, 0},
    '{1, 12'hAAA,  32'sh55555555,   32'shAAAAAAAA,   0, 0},
    '{0, 12'h555,  32'shAAAAAAAA,   32'sh55555555,   0, 0},
    '{1, 12'd5,    32'sd0,          -32'sd1,         0, 0},
    '{0, 12'd5,    32'sd0,          32'sd1,          0, 0}
  };

  function automatic elem_item_t rand_elem(int hot);
    elem_item_t it;
    it.starts_step = ($urandom_range(15) == 0);
    it.element_index = (hot != 0) ? 12'($urandom_range(15)) : 12'($urandom);
    it.param_value = $urandom;
    case ($urandom_range(3))
      0: it.grad_value = $urandom;
      1: it.grad_value = $signed(32'($urandom_range(33554432))) - 32'sd16777216;
      2: it.grad_value = $signed(32'($urandom_range(2048))) - 32'sd1024;
      default: it.grad_value = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
    endcase
    return it;
  endfunction

  // stimulus
  initial begin
    elem_item_t it;
    in_ch.valid = 1'b0;
    in_ch.starts_step = 1'b0;
    in_ch.element_index = '0;
    in_ch.param_value = '0;
    in_ch.grad_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = CFG_LEARNING_RATE;
    cfg_ch.wr_data = '0;
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      it.starts_step = rows[i].s;
      it.element_index = rows[i].a;
      it.param_value = rows[i].p;
      it.grad_value = rows[i].g;
      send_elem(it, rows[i].chk, rows[i].want);
    end
    drain();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: begin
          write_reg(CFG_LEARNING_RATE, 24'hFFFFFF);
          write_reg(CFG_FIRST_DECAY, 24'd0);
          write_reg(CFG_SECOND_DECAY, 24'd0);
          write_reg(CFG_STABILITY_TERM, 24'd0);
        end
        2: begin
          write_reg(CFG_LEARNING_RATE, 24'd0);
          write_reg(CFG_FIRST_DECAY, 24'hFFFFFF);
          write_reg(CFG_SECOND_DECAY, 24'hFFFFFF);
          write_reg(CFG_STABILITY_TERM, 24'hFFFFFF);
        end
        default: begin
          write_reg(CFG_LEARNING_RATE, 24'($urandom));
          write_reg(CFG_FIRST_DECAY, 24'($urandom_range(24'hFFFFFF, 24'hC00000)));
          write_reg(CFG_SECOND_DECAY, 24'($urandom_range(24'hFFFFFF, 24'hF00000)));
          write_reg(CFG_STABILITY_TERM, 24'($urandom_range(4096)));
        end
      endcase
      quiet_stretch = (ph == 3);
      for (int k = 0; k < 256; k++) begin
        it = rand_elem(k % 2);
        send_elem(it, 0, 0);
      end
      drain();
    end

    $display("covered %0d items sent, %0d results checked, six register settings",
             n_sent, n_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog: covers the clearing sweep plus ~1550 items with stalls
  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
